FILE: hdl/avt_pkg.sv
// Shared definitions for the affine vertex transform: command codes,
// data widths, saturation limits and the per-column result record.
// No dependencies.
package avt_pkg;

  localparam int unsigned DATA_W            = 32;
  localparam int unsigned PROD_W            = 2 * DATA_W;
  localparam int unsigned NUM_ROWS          = 4;
  localparam int unsigned NUM_COLS          = 3;
  localparam int unsigned LIN_ROWS          = 3;
  localparam int unsigned TRANS_ROW         = 3;
  localparam int unsigned FRAC_BITS_DEFAULT = 16;

  localparam logic       CMD_WRITE   = 1'b0;
  localparam logic       CMD_XFORM   = 1'b1;
  localparam logic [1:0] COL_IGNORED = 2'd3;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     ovf;
  } col_res_t;

endpackage

FILE: hdl/avt_if.sv
// Handshake interfaces for the affine vertex transform: the request
// channel and the result channel. Depends on avt_pkg.
interface avt_req_if import avt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [1:0]               row;
  logic [1:0]               col;
  logic signed [DATA_W-1:0] elem_value;
  logic signed [DATA_W-1:0] vx;
  logic signed [DATA_W-1:0] vy;
  logic signed [DATA_W-1:0] vz;

  modport source (output valid, command, row, col, elem_value, vx, vy, vz,
                  input ready);
  modport sink   (input valid, command, row, col, elem_value, vx, vy, vz,
                  output ready);
endinterface

interface avt_rsp_if import avt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] ox;
  logic signed [DATA_W-1:0] oy;
  logic signed [DATA_W-1:0] oz;
  logic                     overflow;

  modport source (output valid, ox, oy, oz, overflow, input ready);
  modport sink   (input valid, ox, oy, oz, overflow, output ready);
endinterface

FILE: hdl/avt_col_sum.sv
// One output column: shifts three registered products, adds the
// translation at full width and saturates to 32 bits. Depends on avt_pkg.
module avt_col_sum import avt_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic signed [PROD_W-1:0] prod [LIN_ROWS],
  input  logic signed [DATA_W-1:0] trans,
  output col_res_t                 res
);

  localparam int unsigned SH_W  = PROD_W - FRAC_BITS;
  localparam int unsigned SUM_W = SH_W + 2;

  logic signed [SH_W-1:0]  sh [LIN_ROWS];
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-32:0]       hi;
  logic                    ovf;

  always_comb begin
    for (int r = 0; r < LIN_ROWS; r++) begin
      sh[r] = SH_W'(prod[r] >>> FRAC_BITS);
    end
  end

  assign sum = SUM_W'(sh[0]) + SUM_W'(sh[1]) + SUM_W'(sh[2]) + SUM_W'(trans);

  // The sum fits in 32 bits only when every bit from 31 up matches the sign.
  assign hi  = sum[SUM_W-1:31];
  assign ovf = !((&hi) || !(|hi));

  always_comb begin
    res.ovf = ovf;
    if (!ovf) begin
      res.value = sum[DATA_W-1:0];
    end else if (sum[SUM_W-1]) begin
      res.value = S32_MIN;
    end else begin
      res.value = S32_MAX;
    end
  end

endmodule

FILE: hdl/affine_vertex_transform.sv
// Top level of the affine vertex transform: matrix store, input stage,
// product stage and result register. Depends on avt_pkg, avt_if, avt_col_sum.
//
//   channel | dir | payload                                  | handshake
//   req     | in  | command row col elem_value vx vy vz      | valid/ready
//   rsp     | out | ox oy oz overflow                        | valid/ready
//
// One request per cycle is taken while the input stage is free. After a
// transform is accepted it passes the input register, the product register (nine
// 32x32 multipliers), then shift, add and saturate into the result register.
// Reset clears all valid bits and loads the identity matrix.
// A held result stalls only the stages behind it; element writes retire from
// the input stage without waiting for the result side.
module affine_vertex_transform import avt_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  avt_req_if.sink   req,
  avt_rsp_if.source rsp
);

  localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  logic signed [DATA_W-1:0] mtx [NUM_ROWS][NUM_COLS];

  logic                     s1_valid;
  logic                     s1_cmd;
  logic [1:0]               s1_row;
  logic [1:0]               s1_col;
  logic signed [DATA_W-1:0] s1_elem;
  logic signed [DATA_W-1:0] s1_v [LIN_ROWS];

  logic                     s2_valid;
  logic signed [PROD_W-1:0] s2_prod [NUM_COLS][LIN_ROWS];
  logic signed [DATA_W-1:0] s2_trans [NUM_COLS];

  col_res_t col_res [NUM_COLS];

  logic out_free;
  logic s2_free;
  logic s1_move;
  logic s1_free;
  logic s1_write;

  assign out_free  = !rsp.valid || rsp.ready;
  assign s2_free   = !s2_valid || out_free;
  assign s1_move   = s1_valid && ((s1_cmd == CMD_WRITE) || s2_free);
  assign s1_free   = !s1_valid || s1_move;
  assign s1_write  = s1_valid && (s1_cmd == CMD_WRITE) && (s1_col != COL_IGNORED);
  assign req.ready = s1_free;

  // Input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= req.valid;
    end
    if (s1_free && req.valid) begin
      s1_cmd  <= req.command;
      s1_row  <= req.row;
      s1_col  <= req.col;
      s1_elem <= req.elem_value;
      s1_v[0] <= req.vx;
      s1_v[1] <= req.vy;
      s1_v[2] <= req.vz;
    end
  end

  // Matrix store; writes take effect in request order from the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_COLS; c++) begin
          mtx[r][c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (s1_write) begin
      mtx[s1_row][s1_col] <= s1_elem;
    end
  end

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid && (s1_cmd == CMD_XFORM);
    end
    if (s2_free && s1_valid && (s1_cmd == CMD_XFORM)) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        for (int r = 0; r < LIN_ROWS; r++) begin
          s2_prod[c][r] <= PROD_W'(s1_v[r]) * PROD_W'(mtx[r][c]);
        end
        s2_trans[c] <= mtx[TRANS_ROW][c];
      end
    end
  end

  for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
    avt_col_sum #(
      .FRAC_BITS(FRAC_BITS)
    ) u_col_sum (
      .prod  (s2_prod[c]),
      .trans (s2_trans[c]),
      .res   (col_res[c])
    );
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_free) begin
      rsp.valid <= s2_valid;
    end
    if (out_free && s2_valid) begin
      rsp.ox       <= col_res[0].value;
      rsp.oy       <= col_res[1].value;
      rsp.oz       <= col_res[2].value;
      rsp.overflow <= col_res[0].ovf || col_res[1].ovf || col_res[2].ovf;
    end
  end

endmodule

FILE: hdl/avt_checker.sv
// Port-level checks for the affine vertex transform and the bind that
// attaches them to the top level. Depends on avt_pkg.
module avt_checker import avt_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input logic signed [DATA_W-1:0] ox,
  input logic signed [DATA_W-1:0] oy,
  input logic signed [DATA_W-1:0] oz,
  input logic                     overflow
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(ox) && $stable(oy) && $stable(oz)
                               && $stable(overflow))
    else $error("stalled result changed");

  // A raised overflow flag means some component sits at a saturation limit.
  a_ovf_limit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && overflow |->
      (ox == S32_MAX) || (ox == S32_MIN) || (oy == S32_MAX) ||
      (oy == S32_MIN) || (oz == S32_MAX) || (oz == S32_MIN))
    else $error("overflow without a saturated component");

  // Results come only from transforms already in the pipeline, never right
  // out of reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind affine_vertex_transform avt_checker u_avt_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .ox        (rsp.ox),
  .oy        (rsp.oy),
  .oz        (rsp.oz),
  .overflow  (rsp.overflow)
);
